[hw/rtl/dq_pkg.sv]
// Shared constants, types and index helpers for the double-ended queue.
package dq_pkg;

  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 64;
  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_REVERSE    = 3'd4;
  localparam logic [2:0] OP_QUERY      = 3'd5;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic  en;
    idx_t  addr;
    word_t data;
  } dq_wr_t;

  // Ring index a + b, both below DEPTH.
  function automatic idx_t slot_add(idx_t a, idx_t b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (IDX_W+1)'(DEPTH)) begin
      s = s - (IDX_W+1)'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  // Ring index a - 1.
  function automatic idx_t slot_dec(idx_t a);
    idx_t r;
    if (a == '0) begin
      r = idx_t'(DEPTH - 1);
    end else begin
      r = a - idx_t'(1);
    end
    return r;
  endfunction

endpackage

[hw/rtl/dq_ram.sv]
// Ring store: one write port, two registered read ports.
module dq_ram (
  input  logic           clk,
  input  dq_pkg::dq_wr_t wr,
  input  dq_pkg::idx_t   raddr_a,
  input  dq_pkg::idx_t   raddr_b,
  output dq_pkg::word_t  rdata_a,
  output dq_pkg::word_t  rdata_b
);

  dq_pkg::word_t mem [dq_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[hw/rtl/double_ended_queue.sv]
// Top level of the double-ended queue over a ring store.
//
//  channel | dir | payload                                  | accepted when
//  s_*     | in  | tuser: operation; tdata: data_word       | s_tvalid & s_tready
//  m_*     | out | tdata: front, back, empty, count, status | m_tvalid & m_tready
//
// Each operation steps through: accept and write the ring store, issue both
// reads, then load the result register; the store's read is registered.
// A new operation is accepted while the result waits. A stalled result holds
// the load step. Reset (rst, synchronous) empties the queue and clears the
// direction flag; the store itself is not cleared.
module double_ended_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [2:0]   s_tuser,   // [2:0] operation
  input  logic [63:0]  s_tdata,   // [63:0] data_word
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata    // [63:0] front_word, [127:64] back_word,
                                  // [128] is_empty, [133:129] entry_count,
                                  // [135:134] status
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;

  localparam int WORD_EXT = dq_pkg::WORD_BITS + 64;

  logic [1:0]    state;
  dq_pkg::idx_t  head;
  dq_pkg::cnt_t  occ;
  logic          rev;
  logic [1:0]    status;

  dq_pkg::dq_wr_t wr;
  dq_pkg::idx_t   raddr_a, raddr_b;
  dq_pkg::word_t  rdata_a, rdata_b;
  dq_pkg::cnt_t   occ_m1;

  logic          accept, load, is_push, is_pop, at_front, full, empty;
  logic [2:0]    op;
  dq_pkg::word_t word_in;
  dq_pkg::word_t front_w, back_w;
  logic [WORD_EXT-1:0] front_ext, back_ext;
  logic [dq_pkg::CNT_W+4:0] cnt_ext;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign load     = (state == S_LOAD) && (!m_tvalid || m_tready);

  assign op       = s_tuser;
  assign word_in  = s_tdata[dq_pkg::WORD_BITS-1:0];
  assign is_push  = (op == dq_pkg::OP_PUSH_FRONT) || (op == dq_pkg::OP_PUSH_BACK);
  assign is_pop   = (op == dq_pkg::OP_POP_FRONT) || (op == dq_pkg::OP_POP_BACK);
  // Physical end touched by a push or pop, after the direction flag.
  assign at_front = ((op == dq_pkg::OP_PUSH_FRONT) || (op == dq_pkg::OP_POP_FRONT)) != rev;
  assign full     = (occ == dq_pkg::cnt_t'(dq_pkg::DEPTH));
  assign empty    = (occ == '0);

  always_comb begin
    wr.en   = accept && is_push && !full;
    wr.data = word_in;
    if (at_front) begin
      wr.addr = dq_pkg::slot_dec(head);
    end else begin
      wr.addr = dq_pkg::slot_add(head, occ[dq_pkg::IDX_W-1:0]);
    end
  end

  // Read addresses follow the registers; they hold while no beat is accepted.
  assign occ_m1  = occ - dq_pkg::cnt_t'(1);
  assign raddr_a = head;
  assign raddr_b = dq_pkg::slot_add(head, occ_m1[dq_pkg::IDX_W-1:0]);

  dq_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      occ   <= '0;
      rev   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_READ;
            if (is_push) begin
              if (!full) begin
                occ <= occ + dq_pkg::cnt_t'(1);
                if (at_front) begin
                  head <= dq_pkg::slot_dec(head);
                end
              end
            end else if (is_pop) begin
              if (!empty) begin
                occ <= occ - dq_pkg::cnt_t'(1);
                if (at_front) begin
                  head <= dq_pkg::slot_add(head, dq_pkg::idx_t'(1));
                end
              end
            end else if (op == dq_pkg::OP_REVERSE) begin
              rev <= !rev;
            end
          end
        end
        S_READ: state <= S_LOAD;
        S_LOAD: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (is_push && full) begin
        status <= dq_pkg::ST_OVERFLOW;
      end else if (is_pop && empty) begin
        status <= dq_pkg::ST_UNDERFLOW;
      end else begin
        status <= dq_pkg::ST_DONE;
      end
    end
  end

  always_comb begin
    if (empty) begin
      front_w = '0;
      back_w  = '0;
    end else if (rev) begin
      front_w = rdata_b;
      back_w  = rdata_a;
    end else begin
      front_w = rdata_a;
      back_w  = rdata_b;
    end
    front_ext = {64'd0, front_w};
    back_ext  = {64'd0, back_w};
    cnt_ext   = {5'd0, occ};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {status, cnt_ext[4:0], empty, back_ext[63:0], front_ext[63:0]};
    end
  end

endmodule

[hw/rtl/dq_checker.sv]
// Port-level checks for the double-ended queue, bound to the top level.
module dq_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [135:0] m_tdata
);

  // A stalled result beat keeps its data.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // An empty queue shows zero words at both ends.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[128] |-> m_tdata[127:0] == 128'd0)
    else $error("empty result carries nonzero words");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[135:134] != 2'd3)
    else $error("undefined status code");

  // One operation at a time: input side closes right after an accept.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second operation accepted while one is in flight");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

[verif/tb_double_ended_queue.sv]
// Self-checking stream testbench for the double-ended queue: directed corners, then random traffic.
module tb_double_ended_queue;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_RANDOM  = 1100;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 4000;
  localparam int DRAIN_WAIT  = 8;

  // Same layout as m_tdata, lowest field last.
  typedef struct packed {
    logic [1:0]    status;
    dq_pkg::cnt_t  count;
    logic          empty;
    dq_pkg::word_t back;
    dq_pkg::word_t front;
  } deque_result_t;

  class deque_scoreboard;
    dq_pkg::word_t   ring[dq_pkg::DEPTH];
    int unsigned     head;
    int unsigned     occ;
    bit              rev;
    deque_result_t   expected_q[$];
    int unsigned     errors;

    function new();
      head   = 0;
      occ    = 0;
      rev    = 1'b0;
      errors = 0;
    endfunction

    // Apply one accepted operation to the shadow deque and queue its result.
    function void note_input(logic [2:0] op, dq_pkg::word_t w);
      deque_result_t r;
      dq_pkg::word_t pf;
      dq_pkg::word_t pb;
      r.status = dq_pkg::ST_DONE;
      case (op)
        dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK: begin
          if (occ == dq_pkg::DEPTH) begin
            r.status = dq_pkg::ST_OVERFLOW;
          end else if ((op == dq_pkg::OP_PUSH_FRONT) != rev) begin
            head       = (head + dq_pkg::DEPTH - 1) % dq_pkg::DEPTH;
            ring[head] = w;
            occ++;
          end else begin
            ring[(head + occ) % dq_pkg::DEPTH] = w;
            occ++;
          end
        end
        dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK: begin
          if (occ == 0) begin
            r.status = dq_pkg::ST_UNDERFLOW;
          end else if ((op == dq_pkg::OP_POP_FRONT) != rev) begin
            head = (head + 1) % dq_pkg::DEPTH;
            occ--;
          end else begin
            occ--;
          end
        end
        dq_pkg::OP_REVERSE: begin
          rev = !rev;
        end
        default: begin
        end
      endcase
      pf = '0;
      pb = '0;
      if (occ != 0) begin
        pf = ring[head];
        pb = ring[(head + occ - 1) % dq_pkg::DEPTH];
      end
      r.front = rev ? pb : pf;
      r.back  = rev ? pf : pb;
      r.empty = (occ == 0);
      r.count = dq_pkg::cnt_t'(occ);
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [135:0] beat);
      deque_result_t got;
      deque_result_t exp_r;
      got = beat;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, beat);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.front !== exp_r.front) begin
        $display("%0t: front_word expected %h actual %h", $time, exp_r.front, got.front);
        errors++;
      end
      if (got.back !== exp_r.back) begin
        $display("%0t: back_word expected %h actual %h", $time, exp_r.back, got.back);
        errors++;
      end
      if (got.empty !== exp_r.empty) begin
        $display("%0t: is_empty expected %0d actual %0d", $time, exp_r.empty, got.empty);
        errors++;
      end
      if (got.count !== exp_r.count) begin
        $display("%0t: entry_count expected %0d actual %0d", $time, exp_r.count, got.count);
        errors++;
      end
      if (got.status !== exp_r.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [2:0]   s_tuser = dq_pkg::OP_QUERY;
  logic [63:0]  s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [135:0] m_tdata;

  deque_scoreboard deque_sb = new();
  bit              hold_req = 1'b0;
  int unsigned     idle_cycles = 0;

  double_ended_queue dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // Sample both handshakes on the rising edge; watchdog on stalls.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        deque_sb.note_input(s_tuser, s_tdata);
      end
      if (m_tvalid && m_tready) begin
        deque_sb.check_result(m_tdata);
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("double_ended_queue regression: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Receiver: random stall pattern picked from four kinds; long hold-off on request.
  initial begin
    int unsigned cyc;
    int unsigned pat;
    cyc = 0;
    pat = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (cyc % 64 == 0) begin
          pat = $urandom_range(0, 3);
        end
        case (pat)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 3) != 0);
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= ((cyc % 8) < 5);
        endcase
      end
      cyc++;
    end
  end

  task automatic send_beat(input logic [2:0] op, input logic [63:0] w);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= w;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic pause_send(input int unsigned n);
    @(negedge clk);
    s_tvalid <= 1'b0;
    s_tuser  <= 3'($urandom_range(0, 7));
    s_tdata  <= {$urandom(), $urandom()};
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic wait_drained();
    while (deque_sb.expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] pick_word();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom(), $urandom()};
  endfunction

  // Weighted op choice: push_pct pushes, pop_pct pops, rest reverse/query/unused codes.
  function automatic logic [2:0] pick_op(input int unsigned push_pct, input int unsigned pop_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < push_pct) begin
      return $urandom_range(0, 1) ? dq_pkg::OP_PUSH_FRONT : dq_pkg::OP_PUSH_BACK;
    end
    if (r < push_pct + pop_pct) begin
      return $urandom_range(0, 1) ? dq_pkg::OP_POP_FRONT : dq_pkg::OP_POP_BACK;
    end
    case ($urandom_range(0, 5))
      0, 1, 2: return dq_pkg::OP_REVERSE;
      3, 4:    return dq_pkg::OP_QUERY;
      default: return 3'($urandom_range(6, 7));
    endcase
  endfunction

  initial begin
    int unsigned sent;
    int unsigned burst;
    int unsigned push_pct;
    int unsigned pop_pct;
    bit          held;
    bit          drained;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Corners: underflow on empty, reverse on empty, extreme words, unused codes,
    // fill to full, then overflow at both ends.
    send_beat(dq_pkg::OP_QUERY, '1);
    send_beat(dq_pkg::OP_POP_FRONT, '0);
    send_beat(dq_pkg::OP_POP_BACK, '1);
    send_beat(dq_pkg::OP_REVERSE, '0);
    send_beat(dq_pkg::OP_PUSH_FRONT, '1);
    send_beat(dq_pkg::OP_PUSH_BACK, '0);
    send_beat(3'd6, '1);
    send_beat(3'd7, '0);
    send_beat(dq_pkg::OP_REVERSE, '1);
    for (int i = 0; i < dq_pkg::DEPTH - 2; i++) begin
      send_beat((i % 2) ? dq_pkg::OP_PUSH_FRONT : dq_pkg::OP_PUSH_BACK, pick_word());
    end
    send_beat(dq_pkg::OP_PUSH_FRONT, '1);
    send_beat(dq_pkg::OP_PUSH_BACK, '1);
    pause_send(1);
    wait_drained();

    sent     = 0;
    held     = 1'b0;
    drained  = 1'b0;
    push_pct = 45;
    pop_pct  = 40;
    while (sent < NUM_RANDOM) begin
      if (sent % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: begin push_pct = 70; pop_pct = 20; end
          1: begin push_pct = 20; pop_pct = 70; end
          default: begin push_pct = 42; pop_pct = 42; end
        endcase
      end
      if (!held && sent >= 300) begin
        // Hold the output and keep offering: the block must fill and stall input.
        held     = 1'b1;
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++) begin
          send_beat(pick_op(push_pct, pop_pct), pick_word());
        end
        sent += 40;
      end else if (!drained && sent >= 600) begin
        drained = 1'b1;
        pause_send(1);
        wait_drained();
      end
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst; i++) begin
        send_beat(pick_op(push_pct, pop_pct), pick_word());
      end
      sent += burst;
      if ($urandom_range(0, 1)) begin
        pause_send($urandom_range(1, 12));
      end
    end

    pause_send(1);
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (deque_sb.errors == 0 && deque_sb.expected_q.size() == 0) begin
      $display("double_ended_queue regression: pass");
    end else begin
      $display("double_ended_queue regression: fail");
    end
    $finish;
  end

endmodule
